// File: hdl/sca_pkg.sv
// ---------------------------------------------------------------------------
// Segment coverage package
// Widths, types and codes shared by the coverage pipeline and its units.
// ---------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  // Pixel coordinate bits and subpixel fraction bits of the endpoints.
  localparam int PIX_W = 12;
  localparam int SUB_W = 4;

  // Register widths.
  localparam int REG_W = 16;
  localparam int SW_W  = 12;
  localparam int CA_W  = 8;
  localparam int IDX_W = 3;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_END_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_Y   = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ALPHA   = 3'd5;

  // Pixel centre in units of 2^-(SUB_W+1): ((2x+1) << SUB_W).
  localparam int CEN_W = PIX_W + SUB_W + 1;
  // Offset from start point, signed.
  localparam int A_W   = ((CEN_W + 1 > REG_W + 1) ? CEN_W + 1 : REG_W + 1) + 1;
  // Segment direction, signed (twice the endpoint difference).
  localparam int D_W   = REG_W + 2;
  localparam int PR_W  = A_W + D_W;
  localparam int DOT_W = PR_W + 1;
  localparam int LEN_W = 2 * D_W;

  // Projection parameter: T_FB fraction bits, range 0 to 1.
  localparam int T_FB  = 16;
  localparam int T_W   = T_FB + 1;

  // Offset vector before rounding and after rounding to 1/256 pixel.
  localparam int OX_W  = A_W + T_FB + 2;
  localparam int RSH   = SUB_W + 9;
  localparam int R_W   = OX_W - RSH;

  // Square root radicand and iteration count.
  localparam int N_W   = 2 * R_W + 2;
  localparam int SQ_NIT = N_W / 2;

  // Intensity and stroke edge in 1/256 pixel.
  localparam int OUTER_W = SW_W + 4;
  localparam int INT_W   = 9;

  // How the projection parameter is formed.
  typedef enum logic [1:0] {
    T_DIV  = 2'd0,
    T_ZERO = 2'd1,
    T_ONE  = 2'd2
  } t_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic signed [A_W-1:0]   ax;
    logic signed [A_W-1:0]   ay;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    t_mode_e                 mode;
  } geo_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
  } pix_t;

endpackage

`default_nettype wire

// File: hdl/sca_div.sv
// ---------------------------------------------------------------------------
// Projection divider
// Pipelined restoring divider: one quotient bit of dot/len2 per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module sca_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [sca_pkg::LEN_W-1:0]  rem_i,
  input  wire logic [sca_pkg::LEN_W-1:0]  len_i,
  input  wire sca_pkg::geo_t              geo_i,
  output logic                            valid_o,
  output logic [sca_pkg::T_FB-1:0]        quo_o,
  output sca_pkg::geo_t                   geo_o
);
  import sca_pkg::*;

  logic               v_q   [1:T_FB];
  logic [LEN_W-1:0]   rem_q [1:T_FB];
  logic [LEN_W-1:0]   len_q [1:T_FB];
  logic [T_FB-1:0]    quo_q [1:T_FB];
  geo_t               geo_q [1:T_FB];

  for (genvar k = 0; k < T_FB; k++) begin : g_stage
    logic             v_s;
    logic [LEN_W-1:0] rem_s;
    logic [LEN_W-1:0] len_s;
    logic [T_FB-1:0]  quo_s;
    geo_t             geo_s;
    logic [LEN_W:0]   rem2;
    logic             ge;
    logic [LEN_W-1:0] rem_d;

    // The first stage takes the incoming word, later stages the one before.
    if (k == 0) begin : g_first
      assign v_s   = valid_i;
      assign rem_s = rem_i;
      assign len_s = len_i;
      assign quo_s = '0;
      assign geo_s = geo_i;
    end else begin : g_next
      assign v_s   = v_q[k];
      assign rem_s = rem_q[k];
      assign len_s = len_q[k];
      assign quo_s = quo_q[k];
      assign geo_s = geo_q[k];
    end

    // Remainder stays below len2, so the doubled value fits one more bit.
    always_comb begin
      rem2  = {rem_s, 1'b0};
      ge    = rem2 >= {1'b0, len_s};
      rem_d = ge ? LEN_W'(rem2 - {1'b0, len_s}) : rem2[LEN_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        len_q[k+1] <= len_s;
        quo_q[k+1] <= {quo_s[T_FB-2:0], ge};
        geo_q[k+1] <= geo_s;
      end
    end
  end

  assign valid_o = v_q[T_FB];
  assign quo_o   = quo_q[T_FB];
  assign geo_o   = geo_q[T_FB];

endmodule

`default_nettype wire

// File: hdl/sca_sqrt.sv
// ---------------------------------------------------------------------------
// Distance square root
// Pipelined integer square root: one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module sca_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [sca_pkg::N_W-1:0]     rad_i,
  input  wire sca_pkg::pix_t               pix_i,
  output logic                             valid_o,
  output logic [sca_pkg::SQ_NIT-1:0]       root_o,
  output sca_pkg::pix_t                    pix_o
);
  import sca_pkg::*;

  logic             v_q   [1:SQ_NIT];
  logic [N_W-1:0]   rad_q [1:SQ_NIT];
  logic [N_W-1:0]   res_q [1:SQ_NIT];
  pix_t             pix_q [1:SQ_NIT];

  for (genvar k = 0; k < SQ_NIT; k++) begin : g_stage
    localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (SQ_NIT - 1 - k));
    logic           v_s;
    logic [N_W-1:0] rad_s;
    logic [N_W-1:0] res_s;
    pix_t           pix_s;
    logic [N_W-1:0] trial;
    logic           ge;
    logic [N_W-1:0] rad_d;
    logic [N_W-1:0] res_d;

    // The first stage takes the incoming word, later stages the one before.
    if (k == 0) begin : g_first
      assign v_s   = valid_i;
      assign rad_s = rad_i;
      assign res_s = '0;
      assign pix_s = pix_i;
    end else begin : g_next
      assign v_s   = v_q[k];
      assign rad_s = rad_q[k];
      assign res_s = res_q[k];
      assign pix_s = pix_q[k];
    end

    always_comb begin
      trial = res_s + BIT;
      ge    = rad_s >= trial;
      rad_d = ge ? rad_s - trial : rad_s;
      res_d = ge ? (res_s >> 1) + BIT : res_s >> 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1] <= rad_d;
        res_q[k+1] <= res_d;
        pix_q[k+1] <= pix_s;
      end
    end
  end

  assign valid_o = v_q[SQ_NIT];
  assign root_o  = res_q[SQ_NIT][SQ_NIT-1:0];
  assign pix_o   = pix_q[SQ_NIT];

endmodule

`default_nettype wire

// File: hdl/segment_coverage_alpha_core.sv
// ---------------------------------------------------------------------------
// Segment coverage alpha core
// Antialiased coverage of one pixel centre by a thick line segment.
// ---------------------------------------------------------------------------
// Usage: pixel words enter on the s_axis channel, one (x, y) pair per word.
// Each word produces exactly one result word on the m_axis channel carrying
// the pixel coordinates, the coverage alpha in tdata and the draw flag in
// tuser. Segment endpoints, stroke width and opacity are written through the
// cfg channel by register index; cfg_ready_o is always high, and writes must
// only happen while no pixel is in flight.
// Throughput is one word per cycle while the receiver does not stall: the
// projection divider (16 stages, one quotient bit each) and the square root
// (25 stages, one root bit each) are fully pipelined, and most of the depth
// comes from those two units.
// The whole pipeline advances as one when the output register is empty or
// being taken; when the receiver stalls, every stage holds and s_axis_tready
// drops in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with a zero-length
// segment at the origin, a stroke width of one pixel and full opacity.
// ---------------------------------------------------------------------------
`default_nettype none

module segment_coverage_alpha_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sca_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [sca_pkg::REG_W-1:0]    cfg_data_i,
  // Pixel input: [11:0] pixel_x, [23:12] pixel_y.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,
  // Result: [11:0] out_x, [23:12] out_y, [31:24] coverage_alpha.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [31:0]                       m_axis_tdata,
  // Result flag: [0] draw.
  output logic                              m_axis_tuser
);
  import sca_pkg::*;

  // Configuration registers.
  logic signed [REG_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [SW_W-1:0]         width_q;
  logic [CA_W-1:0]         alpha_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      width_q   <= SW_W'(16);
      alpha_q   <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_X: start_x_q <= cfg_data_i;
        REG_START_Y: start_y_q <= cfg_data_i;
        REG_END_X:   end_x_q   <= cfg_data_i;
        REG_END_Y:   end_y_q   <= cfg_data_i;
        REG_WIDTH:   width_q   <= cfg_data_i[SW_W-1:0];
        REG_ALPHA:   alpha_q   <= cfg_data_i[CA_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the output slot frees up.
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: offsets from the start point and the segment direction, in
  // units of 2^-(SUB_W+1) pixel.
  logic [PIX_W-1:0]      in_x, in_y;
  logic signed [A_W-1:0] cx, cy, sx, sy;
  logic                  v1_q;
  geo_t                  g1_q;

  assign in_x = s_axis_tdata[PIX_W-1:0];
  assign in_y = s_axis_tdata[12 +: PIX_W];

  always_comb begin
    cx = A_W'({in_x, 1'b1}) <<< SUB_W;
    cy = A_W'({in_y, 1'b1}) <<< SUB_W;
    sx = A_W'(start_x_q) <<< 1;
    sy = A_W'(start_y_q) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q.px   <= in_x;
      g1_q.py   <= in_y;
      g1_q.ax   <= cx - sx;
      g1_q.ay   <= cy - sy;
      g1_q.dx   <= (D_W'(end_x_q) - D_W'(start_x_q)) <<< 1;
      g1_q.dy   <= (D_W'(end_y_q) - D_W'(start_y_q)) <<< 1;
      g1_q.mode <= T_DIV;
    end
  end

  // Stage 2: the four products for the dot product and squared length.
  logic                   v2_q;
  geo_t                   g2_q;
  logic signed [PR_W-1:0] pxd_q, pyd_q;
  logic [LEN_W-1:0]       sqx_q, sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_q  <= g1_q;
      pxd_q <= PR_W'(g1_q.ax) * PR_W'(g1_q.dx);
      pyd_q <= PR_W'(g1_q.ay) * PR_W'(g1_q.dy);
      sqx_q <= LEN_W'(LEN_W'(g1_q.dx) * LEN_W'(g1_q.dx));
      sqy_q <= LEN_W'(LEN_W'(g1_q.dy) * LEN_W'(g1_q.dy));
    end
  end

  // Stage 3: sums and the choice between the clamped ends and a division.
  logic                    v3_q;
  geo_t                    g3_q;
  geo_t                    g3_d;
  logic [LEN_W-1:0]        rem3_q, len3_q;
  logic signed [DOT_W-1:0] dot;
  logic [LEN_W-1:0]        len2;
  t_mode_e                 mode3;

  always_comb begin
    dot  = DOT_W'(pxd_q) + DOT_W'(pyd_q);
    len2 = sqx_q + sqy_q;
    if (len2 == '0 || dot <= 0) begin
      mode3 = T_ZERO;
    end else if (dot >= $signed(DOT_W'(len2))) begin
      mode3 = T_ONE;
    end else begin
      mode3 = T_DIV;
    end
    g3_d      = g2_q;
    g3_d.mode = mode3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g3_q      <= g3_d;
      // Only used when dot lies strictly between zero and len2.
      rem3_q    <= dot[LEN_W-1:0];
      len3_q    <= len2;
    end
  end

  // Divider: t = floor(dot * 2^16 / len2).
  logic            vd;
  logic [T_FB-1:0] quo;
  geo_t            gd;

  sca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rem_i   (rem3_q),
    .len_i   (len3_q),
    .geo_i   (g3_q),
    .valid_o (vd),
    .quo_o   (quo),
    .geo_o   (gd)
  );

  // Stage T: the projection parameter with its clamped cases.
  logic           vt_q;
  geo_t           gt_q;
  logic [T_W-1:0] t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (en) begin
      vt_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gt_q <= gd;
      case (gd.mode)
        T_ZERO:  t_q <= '0;
        T_ONE:   t_q <= T_W'(1) << T_FB;
        default: t_q <= {1'b0, quo};
      endcase
    end
  end

  // Stage P1: t times the direction.
  logic                   vp1_q;
  geo_t                   gp1_q;
  logic signed [OX_W-1:0] tdx_q, tdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
    end else if (en) begin
      vp1_q <= vt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gp1_q <= gt_q;
      tdx_q <= $signed(OX_W'(t_q)) * OX_W'(gt_q.dx);
      tdy_q <= $signed(OX_W'(t_q)) * OX_W'(gt_q.dy);
    end
  end

  // Stage P2: offset from the closest point, still at full precision.
  logic                   vp2_q;
  pix_t                   pp2_q;
  logic signed [OX_W-1:0] ox_q, oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp2_q <= 1'b0;
    end else if (en) begin
      vp2_q <= vp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp2_q.px <= gp1_q.px;
      pp2_q.py <= gp1_q.py;
      ox_q     <= (OX_W'(gp1_q.ax) <<< T_FB) - tdx_q;
      oy_q     <= (OX_W'(gp1_q.ay) <<< T_FB) - tdy_q;
    end
  end

  // Stage P3: magnitudes rounded to 1/256 pixel, halves away from zero.
  logic            vp3_q;
  pix_t            pp3_q;
  logic [R_W-1:0]  rx_q, ry_q;
  logic [OX_W-1:0] mx, my, sumx, sumy;

  always_comb begin
    mx   = ox_q[OX_W-1] ? OX_W'(-ox_q) : OX_W'(ox_q);
    my   = oy_q[OX_W-1] ? OX_W'(-oy_q) : OX_W'(oy_q);
    sumx = mx + (OX_W'(1) << (RSH - 1));
    sumy = my + (OX_W'(1) << (RSH - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp3_q <= 1'b0;
    end else if (en) begin
      vp3_q <= vp2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp3_q <= pp2_q;
      rx_q  <= sumx[OX_W-1:RSH];
      ry_q  <= sumy[OX_W-1:RSH];
    end
  end

  // Stage P4: squares of the rounded offsets.
  logic             vp4_q;
  pix_t             pp4_q;
  logic [2*R_W-1:0] rx2_q, ry2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp4_q <= 1'b0;
    end else if (en) begin
      vp4_q <= vp3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp4_q <= pp3_q;
      rx2_q <= (2*R_W)'(rx_q) * (2*R_W)'(rx_q);
      ry2_q <= (2*R_W)'(ry_q) * (2*R_W)'(ry_q);
    end
  end

  // Stage P5: squared distance.
  logic           vp5_q;
  pix_t           pp5_q;
  logic [N_W-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp5_q <= 1'b0;
    end else if (en) begin
      vp5_q <= vp4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp5_q <= pp4_q;
      rad_q <= N_W'(rx2_q) + N_W'(ry2_q);
    end
  end

  // Square root: distance in 1/256 pixel.
  logic              vs;
  logic [SQ_NIT-1:0] distance;
  pix_t              ps;

  sca_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp5_q),
    .rad_i   (rad_q),
    .pix_i   (pp5_q),
    .valid_o (vs),
    .root_o  (distance),
    .pix_o   (ps)
  );

  // Stage F1: intensity is the distance inside the soft stroke edge,
  // clamped to one pixel.
  logic               vf_q;
  pix_t               pf_q;
  logic [INT_W-1:0]   inten_q;
  logic               draw_q;
  logic [OUTER_W-1:0] outer;
  logic [SQ_NIT-1:0]  gap;
  logic [INT_W-1:0]   inten;

  always_comb begin
    outer = (OUTER_W'(width_q) << 3) + OUTER_W'(128);
    gap   = SQ_NIT'(outer) - distance;
    if (distance >= SQ_NIT'(outer)) begin
      inten = '0;
    end else if (gap > SQ_NIT'(256)) begin
      inten = INT_W'(256);
    end else begin
      inten = gap[INT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pf_q    <= ps;
      inten_q <= inten;
      draw_q  <= (inten != '0) && (alpha_q != '0) && (width_q != '0);
    end
  end

  // Output register: opacity scaled by intensity.
  logic [CA_W+INT_W-1:0] prod;
  logic [CA_W-1:0]       cov_q;
  pix_t                  po_q;
  logic                  out_draw_q;

  assign prod = (CA_W+INT_W)'(alpha_q) * (CA_W+INT_W)'(inten_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      po_q       <= pf_q;
      out_draw_q <= draw_q;
      cov_q      <= draw_q ? prod[8 +: CA_W] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {cov_q, 12'(po_q.py), 12'(po_q.px)};
  assign m_axis_tuser  = out_draw_q;

endmodule

`default_nettype wire
